// File: rtl/lecb_pkg.sv
// Shared types and constants for the line edit cursor buffer.
`default_nettype none

package lecb_pkg;

    localparam int LECB_CAPACITY = 128;

    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int STEP_W  = 8;
    localparam int INDEX_W = 7;
    localparam int POS_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TYPE  = 3'd0,
        CMD_BKSP  = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_HOME  = 3'd4,
        CMD_END   = 3'd5,
        CMD_READ  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_INS_CHAR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  line_length;
        logic [CHAR_W-1:0] read_char;
        logic              status;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/lecb_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module lecb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lecb_seq.sv
// Edit sequencer: cursor/length registers and the read-shift-write loop over the line RAM.
`default_nettype none

module lecb_seq #(
    parameter int CAPACITY = lecb_pkg::LECB_CAPACITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [lecb_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [lecb_pkg::CHAR_W-1:0]    s_char_code,
    input  wire logic [lecb_pkg::STEP_W-1:0]    s_move_steps,
    input  wire logic [lecb_pkg::INDEX_W-1:0]   s_read_index,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output lecb_pkg::res_t                      res,
    output logic                                mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
    output logic [lecb_pkg::CHAR_W-1:0]         mem_wr_data,
    output logic                                mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
    input  wire logic [lecb_pkg::CHAR_W-1:0]    mem_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int MW = (PW > lecb_pkg::STEP_W) ? PW : lecb_pkg::STEP_W;

    lecb_pkg::state_t state_reg, state_next;

    logic [PW-1:0]                 cursor_reg, cursor_next;
    logic [PW-1:0]                 length_reg, length_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic                          rd_busy_reg, rd_busy_next;
    logic                          rd_pend_reg, rd_pend_next;
    logic                          ins_reg, ins_next;
    logic [lecb_pkg::CHAR_W-1:0]   ch_reg, ch_next;
    logic                          status_reg, status_next;
    logic                          rsel_reg, rsel_next;

    logic          line_full;
    logic          tail_nonempty;
    logic          at_home;
    logic          idx_ok;
    logic          last_rd;
    logic          shift_done;
    logic [MW-1:0] steps_w;
    logic [MW-1:0] cur_w;
    logic [MW-1:0] rem_w;

    assign line_full     = (length_reg == PW'(CAPACITY));
    assign tail_nonempty = (cursor_reg < length_reg);
    assign at_home       = (cursor_reg == '0);
    assign idx_ok        = (MW'(s_read_index) < MW'(length_reg));
    assign shift_done    = !rd_busy_reg && !rd_pend_reg;
    assign steps_w       = MW'(s_move_steps);
    assign cur_w         = MW'(cursor_reg);
    assign rem_w         = MW'(length_reg - cursor_reg);

    // insert walks down from length-1 to cursor, delete walks up from cursor to length-1
    assign last_rd = ins_reg ? (ptr_reg == AW'(cursor_reg))
                             : (ptr_reg == AW'(length_reg - PW'(1)));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lecb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_cmd)
                        lecb_pkg::CMD_TYPE: begin
                            if (line_full) begin
                                state_next = lecb_pkg::ST_RESULT;
                            end else if (tail_nonempty) begin
                                state_next = lecb_pkg::ST_SHIFT;
                            end else begin
                                state_next = lecb_pkg::ST_INS_CHAR;
                            end
                        end
                        lecb_pkg::CMD_BKSP: begin
                            if (!at_home && tail_nonempty) begin
                                state_next = lecb_pkg::ST_SHIFT;
                            end else begin
                                state_next = lecb_pkg::ST_RESULT;
                            end
                        end
                        default: state_next = lecb_pkg::ST_RESULT;
                    endcase
                end
            end
            lecb_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    state_next = ins_reg ? lecb_pkg::ST_INS_CHAR : lecb_pkg::ST_RESULT;
                end
            end
            lecb_pkg::ST_INS_CHAR: state_next = lecb_pkg::ST_RESULT;
            lecb_pkg::ST_RESULT: begin
                if (res_ready) begin
                    state_next = lecb_pkg::ST_IDLE;
                end
            end
            default: state_next = lecb_pkg::ST_IDLE;
        endcase
    end

    // outputs and RAM controls
    always_comb begin
        s_ready     = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = ptr_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = wr_addr_reg;
        mem_wr_data = mem_rd_data;
        unique case (state_reg)
            lecb_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                mem_rd_en   = s_valid && (s_cmd == lecb_pkg::CMD_READ) && idx_ok;
                mem_rd_addr = AW'(s_read_index);
            end
            lecb_pkg::ST_SHIFT: begin
                mem_rd_en = rd_busy_reg;
                mem_wr_en = rd_pend_reg;
            end
            lecb_pkg::ST_INS_CHAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(cursor_reg);
                mem_wr_data = ch_reg;
            end
            lecb_pkg::ST_RESULT: res_valid = 1'b1;
            default: ;
        endcase
    end

    // read data is held by the RAM until the next read, so RESULT can use it directly
    always_comb begin
        res.cursor_pos  = lecb_pkg::POS_W'(cursor_reg);
        res.line_length = lecb_pkg::POS_W'(length_reg);
        res.read_char   = rsel_reg ? mem_rd_data : '0;
        res.status      = status_reg;
    end

    // datapath next values
    always_comb begin
        cursor_next  = cursor_reg;
        length_next  = length_reg;
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        rd_busy_next = rd_busy_reg;
        rd_pend_next = rd_pend_reg;
        ins_next     = ins_reg;
        ch_next      = ch_reg;
        status_next  = status_reg;
        rsel_next    = rsel_reg;
        unique case (state_reg)
            lecb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    ch_next      = s_char_code;
                    status_next  = 1'b0;
                    rsel_next    = 1'b0;
                    rd_pend_next = 1'b0;
                    unique case (s_cmd)
                        lecb_pkg::CMD_TYPE: begin
                            ins_next = 1'b1;
                            if (line_full) begin
                                status_next = 1'b1;
                            end else if (tail_nonempty) begin
                                ptr_next     = AW'(length_reg - PW'(1));
                                rd_busy_next = 1'b1;
                            end
                        end
                        lecb_pkg::CMD_BKSP: begin
                            ins_next = 1'b0;
                            if (at_home) begin
                                status_next = 1'b1;
                            end else if (tail_nonempty) begin
                                ptr_next     = AW'(cursor_reg);
                                rd_busy_next = 1'b1;
                            end else begin
                                cursor_next = cursor_reg - PW'(1);
                                length_next = length_reg - PW'(1);
                            end
                        end
                        lecb_pkg::CMD_LEFT: begin
                            cursor_next = (steps_w >= cur_w) ? '0 : PW'(cur_w - steps_w);
                        end
                        lecb_pkg::CMD_RIGHT: begin
                            cursor_next = (steps_w >= rem_w) ? length_reg
                                                             : PW'(cur_w + steps_w);
                        end
                        lecb_pkg::CMD_HOME: cursor_next = '0;
                        lecb_pkg::CMD_END:  cursor_next = length_reg;
                        lecb_pkg::CMD_READ: begin
                            if (idx_ok) begin
                                rsel_next = 1'b1;
                            end else begin
                                status_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lecb_pkg::ST_SHIFT: begin
                if (rd_busy_reg) begin
                    wr_addr_next = ins_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                    ptr_next     = ins_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                    rd_busy_next = !last_rd;
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                end
                if (shift_done && !ins_reg) begin
                    cursor_next = cursor_reg - PW'(1);
                    length_next = length_reg - PW'(1);
                end
            end
            lecb_pkg::ST_INS_CHAR: begin
                cursor_next = cursor_reg + PW'(1);
                length_next = length_reg + PW'(1);
            end
            lecb_pkg::ST_RESULT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lecb_pkg::ST_IDLE;
            cursor_reg  <= '0;
            length_reg  <= '0;
            rd_busy_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            length_reg  <= length_next;
            rd_busy_reg <= rd_busy_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        ins_reg     <= ins_next;
        ch_reg      <= ch_next;
        status_reg  <= status_next;
        rsel_reg    <= rsel_next;
    end

endmodule

`default_nettype wire

// File: rtl/line_edit_cursor_buffer.sv
// Line edit cursor buffer: RAM-backed line store, edit sequencer and result register.
// Moves, home, end, reads and refused edits go from accept straight to the result state. Type
// and backspace first shift the N bytes right of the cursor (no shift when N is 0), and type then
// writes its byte. The tail moves one byte per cycle through the one read and one write RAM port.
// One event at a time; the next beat is taken once the sequencer is idle again.
// Reset clears cursor and length to zero; the line RAM is not cleared and needs no sweep.
`default_nettype none

module line_edit_cursor_buffer #(
    parameter int CAPACITY = lecb_pkg::LECB_CAPACITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [lecb_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [lecb_pkg::CHAR_W-1:0]    s_char_code,
    input  wire logic [lecb_pkg::STEP_W-1:0]    s_move_steps,
    input  wire logic [lecb_pkg::INDEX_W-1:0]   s_read_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [lecb_pkg::POS_W-1:0]          m_cursor_pos,
    output logic [lecb_pkg::POS_W-1:0]          m_line_length,
    output logic [lecb_pkg::CHAR_W-1:0]         m_read_char,
    output logic                                m_status
);

    localparam int AW = $clog2(CAPACITY);

    logic                        res_valid;
    logic                        res_ready;
    lecb_pkg::res_t              res;
    lecb_pkg::res_t              out_reg;
    logic                        m_valid_reg, m_valid_next;
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [lecb_pkg::CHAR_W-1:0] mem_wr_data;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [lecb_pkg::CHAR_W-1:0] mem_rd_data;

    lecb_ram #(
        .WIDTH (lecb_pkg::CHAR_W),
        .DEPTH (CAPACITY)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lecb_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_char_code  (s_char_code),
        .s_move_steps (s_move_steps),
        .s_read_index (s_read_index),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // result register: a new beat loads when the slot is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cursor_pos  = out_reg.cursor_pos;
    assign m_line_length = out_reg.line_length;
    assign m_read_char   = out_reg.read_char;
    assign m_status      = out_reg.status;

    a_one_event_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input beat taken while an event is still in progress");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_valid)
        else $error("sequencer result did not reach the output register");

    a_refused_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_read_char == '0)
        else $error("refused event returned a nonzero byte");

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CAPACITY > 255) || (m_cursor_pos <= m_line_length))
        else $error("cursor beyond line length");

endmodule

`default_nettype wire
